FILE: rtl/arp_pkg.sv
package arp_pkg;

	localparam int ENTRIES = 8;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RANK_W = IDX_W;

	localparam logic [1:0] ST_FREE = 2'd0;
	localparam logic [1:0] ST_WAIT = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam logic [3:0] RS_HIT_SEND = 4'd0;
	localparam logic [3:0] RS_QUEUED = 4'd1;
	localparam logic [3:0] RS_QUEUE_FULL = 4'd2;
	localparam logic [3:0] RS_MISS_REQ = 4'd3;
	localparam logic [3:0] RS_BAD_SIZE = 4'd4;
	localparam logic [3:0] RS_UNSUPPORTED = 4'd5;
	localparam logic [3:0] RS_UPDATED = 4'd6;
	localparam logic [3:0] RS_INSERTED = 4'd7;
	localparam logic [3:0] RS_IGNORED = 4'd8;

	localparam logic CFG_MY_IP = 1'b0;
	localparam logic CFG_PEND_LIMIT = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [15:0] pkt_len;
		logic [15:0] hw_type;
		logic [15:0] proto_type;
		logic [7:0]  hw_len;
		logic [7:0]  proto_len;
		logic [15:0] opcode;
		logic [47:0] sender_mac;
		logic [31:0] sender_ip;
		logic [31:0] tgt_ip;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [47:0] mac_out;
		logic [3:0]  release_count;
		logic [3:0]  drop_count;
		logic        send_request;
		logic        send_reply;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic search;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic done;
	} sts_t;

endpackage

FILE: rtl/arp_datapath.sv
module arp_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  arp_pkg::cmd_t      cmd,
	output arp_pkg::sts_t      sts,
	input  arp_pkg::in_item_t  item,
	input  logic [31:0]        my_ip,
	input  logic [3:0]         pending_limit,
	output arp_pkg::out_item_t result
);
	localparam int N = arp_pkg::ENTRIES;
	localparam int IW = arp_pkg::IDX_W;

	logic [1:0]  stat_q [N];
	logic [31:0] ip_q [N];
	logic [47:0] mac_q [N];
	logic [3:0]  pend_q [N];
	logic [IW-1:0] rank_q [N];

	arp_pkg::in_item_t item_q;

	// search results
	logic          hit_q, free_q;
	logic [IW-1:0] hit_idx_q, free_idx_q, lru_idx_q;

	logic [31:0]   key;
	logic          hit_c, free_c;
	logic [IW-1:0] hit_idx_c, free_idx_c, lru_idx_c;

	assign key = item_q.kind ? item_q.sender_ip : item_q.tgt_ip;

	// lowest-index match/free; LRU is highest rank, lowest index on tie
	always_comb begin
		hit_c = 1'b0;
		free_c = 1'b0;
		hit_idx_c = '0;
		free_idx_c = '0;
		lru_idx_c = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (stat_q[i] != arp_pkg::ST_FREE && ip_q[i] == key) begin
				hit_c = 1'b1;
				hit_idx_c = IW'(i);
			end
			if (stat_q[i] == arp_pkg::ST_FREE) begin
				free_c = 1'b1;
				free_idx_c = IW'(i);
			end
		end
		for (int i = 1; i < N; i++)
			if (rank_q[i] > rank_q[lru_idx_c])
				lru_idx_c = IW'(i);
	end

	logic valid_pkt, bad_size, force_ins;
	assign bad_size = item_q.pkt_len < 16'd28;
	assign valid_pkt = item_q.hw_type == 16'd1 && item_q.hw_len == 8'd6 &&
		item_q.proto_type == 16'h0800 && item_q.proto_len == 8'd4 &&
		(item_q.opcode == 16'd1 || item_q.opcode == 16'd2);
	assign force_ins = item_q.tgt_ip == my_ip;

	// update decision
	logic          touch, was_used, wr_new;
	logic [IW-1:0] e;
	logic [IW:0]   old_rank;
	arp_pkg::out_item_t res_c;

	always_comb begin
		res_c = '0;
		touch = 1'b0;
		was_used = 1'b1;
		wr_new = 1'b0;
		e = hit_idx_q;
		if (!item_q.kind) begin
			touch = 1'b1;
			if (hit_q) begin
				if (stat_q[e] == arp_pkg::ST_DONE) begin
					res_c.status = arp_pkg::RS_HIT_SEND;
					res_c.mac_out = mac_q[e];
				end else if (pend_q[e] < pending_limit)
					res_c.status = arp_pkg::RS_QUEUED;
				else
					res_c.status = arp_pkg::RS_QUEUE_FULL;
			end else begin
				wr_new = 1'b1;
				res_c.status = arp_pkg::RS_MISS_REQ;
				res_c.send_request = 1'b1;
				if (free_q) begin
					e = free_idx_q;
					was_used = 1'b0;
				end else begin
					e = lru_idx_q;
					res_c.drop_count = pend_q[lru_idx_q];
				end
			end
		end else if (bad_size)
			res_c.status = arp_pkg::RS_BAD_SIZE;
		else if (!valid_pkt)
			res_c.status = arp_pkg::RS_UNSUPPORTED;
		else begin
			res_c.send_reply = force_ins && item_q.opcode == 16'd1;
			if (hit_q) begin
				touch = 1'b1;
				res_c.status = arp_pkg::RS_UPDATED;
				res_c.mac_out = item_q.sender_mac;
				res_c.release_count = pend_q[e];
			end else if (free_q) begin
				touch = 1'b1;
				wr_new = 1'b1;
				e = free_idx_q;
				was_used = 1'b0;
				res_c.status = arp_pkg::RS_INSERTED;
			end else if (force_ins) begin
				touch = 1'b1;
				wr_new = 1'b1;
				e = lru_idx_q;
				res_c.drop_count = pend_q[lru_idx_q];
				res_c.status = arp_pkg::RS_INSERTED;
			end else
				res_c.status = arp_pkg::RS_IGNORED;
		end
		old_rank = was_used ? {1'b0, rank_q[e]} : (IW + 1)'(N);
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			item_q <= item;
		if (cmd.search) begin
			hit_q <= hit_c;
			free_q <= free_c;
			hit_idx_q <= hit_idx_c;
			free_idx_q <= free_idx_c;
			lru_idx_q <= lru_idx_c;
		end
		if (cmd.update) begin
			result <= res_c;
			if (touch && item_q.kind) begin
				mac_q[e] <= item_q.sender_mac;
				if (wr_new)
					ip_q[e] <= item_q.sender_ip;
			end else if (wr_new) begin
				mac_q[e] <= '0;
				ip_q[e] <= item_q.tgt_ip;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				stat_q[i] <= arp_pkg::ST_FREE;
				pend_q[i] <= '0;
				rank_q[i] <= '0;
			end
			sts <= '0;
		end else begin
			sts.done <= cmd.update;
			if (cmd.update && touch) begin
				for (int i = 0; i < N; i++)
					if (IW'(i) != e && stat_q[i] != arp_pkg::ST_FREE &&
						{1'b0, rank_q[i]} < old_rank)
						rank_q[i] <= rank_q[i] + 1'b1;
				rank_q[e] <= '0;
				if (item_q.kind) begin
					stat_q[e] <= arp_pkg::ST_DONE;
					pend_q[e] <= '0;
				end else if (wr_new) begin
					stat_q[e] <= arp_pkg::ST_WAIT;
					pend_q[e] <= 4'd1;
				end else if (res_c.status == arp_pkg::RS_QUEUED)
					pend_q[e] <= pend_q[e] + 4'd1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && touch |=> rank_q[$past(e)] == '0)
		else $error("touched entry not most recent");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && !item_q.kind |-> res_c.send_reply == 1'b0)
		else $error("reply on resolve");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && res_c.send_request |-> res_c.status == arp_pkg::RS_MISS_REQ)
		else $error("request without miss");

endmodule

FILE: rtl/arp_ctrl.sv
module arp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output arp_pkg::cmd_t cmd,
	input  arp_pkg::sts_t sts
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SRCH = 2'd1;
	localparam logic [1:0] S_UPD = 2'd2;
	localparam logic [1:0] S_OUT = 2'd3;

	logic [1:0] state_q;

	assign in_ready = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign cmd.load = in_valid && in_ready;
	assign cmd.search = state_q == S_SRCH;
	assign cmd.update = state_q == S_UPD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_SRCH;
				S_SRCH: state_q <= S_UPD;
				S_UPD: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT |-> sts.done || $past(state_q) == S_OUT)
		else $error("output without update");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> out_valid)
		else $error("update not followed by output");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("overlap");

endmodule

FILE: rtl/arp_cache_lru_engine.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_item (arp_pkg::in_item_t)
// out     | output    | out_valid / out_ready | out_item (arp_pkg::out_item_t)
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A transaction passes through accept, associative search over all entries,
// table/LRU update, and result held until taken. The controller serializes
// items. Reset clears entry status, pending counts and ranks at once; no sweep.
// A stalled output holds the controller and blocks new input transactions.
// Config is always ready.
module arp_cache_lru_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  arp_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output arp_pkg::out_item_t out_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	logic [31:0]   my_ip_q;
	logic [3:0]    pend_limit_q;
	arp_pkg::cmd_t cmd;
	arp_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	// register file: only indexes 0 and 1 exist
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_ip_q <= '0;
			pend_limit_q <= 4'd4;
		end else if (cfg_valid) begin
			case (cfg_index)
				arp_pkg::CFG_MY_IP: my_ip_q <= cfg_data;
				arp_pkg::CFG_PEND_LIMIT: pend_limit_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	arp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .sts(sts)
	);

	arp_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .sts(sts),
		.item(in_item), .my_ip(my_ip_q), .pending_limit(pend_limit_q),
		.result(out_item)
	);

endmodule
